>>> rtl/core/rnhd_pkg.sv
// Shared constants, codes and types for the nearest-hit distance ray sensor.
// No dependencies; every other file of the block but rnhd_queue refers to it by scoped names.
package rnhd_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int FRAC_BITS       = 12;
  localparam int LEN_W           = 25;
  localparam int LEN_SQ_W        = 2 * LEN_W;
  localparam int QUEUE_DEPTH     = 8;
  localparam int CFG_IDX_W       = 3;

  localparam logic [LEN_W-1:0]    LEN_RESET    = LEN_W'(1 << FRAC_BITS);
  localparam logic [LEN_SQ_W-1:0] LEN_SQ_RESET = LEN_SQ_W'(1) << (2 * FRAC_BITS);

  localparam logic [CFG_IDX_W-1:0] REG_RAY_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RULE_PRESENT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAY_DISABLED = 3'd5;

  typedef enum logic [1:0] {
    ST_DISABLED = 2'd0,
    ST_HIT      = 2'd1,
    ST_NO_HIT   = 2'd2
  } ray_state_t;

  typedef enum logic {
    BK_RUN  = 1'b0,
    BK_ROOT = 1'b1
  } back_state_t;

  typedef struct packed {
    logic [LEN_W-1:0]    ray_length;
    logic [LEN_SQ_W-1:0] len_sq;
    logic                rule_present;
    logic                ray_disabled;
  } cfg_t;

endpackage

>>> rtl/core/rnhd_in_if.sv
// Input channel of the ray sensor: one collision point per transfer.
// Depends on rnhd_pkg for the default coordinate width and length width.
interface rnhd_in_if #(
  parameter int COORD_WIDTH = rnhd_pkg::COORD_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic [COORD_WIDTH-1:0]       point_x;
  logic [COORD_WIDTH-1:0]       point_y;
  logic [COORD_WIDTH-1:0]       point_z;
  logic [COORD_WIDTH-1:0]       host_x;
  logic [COORD_WIDTH-1:0]       host_y;
  logic [COORD_WIDTH-1:0]       host_z;
  logic [rnhd_pkg::LEN_W-1:0]   min_range;
  logic                         point_valid;
  logic                         last_point;

  modport source (
    output valid, point_x, point_y, point_z, host_x, host_y, host_z,
           min_range, point_valid, last_point,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, host_x, host_y, host_z,
           min_range, point_valid, last_point,
    output ready
  );
endinterface

>>> rtl/core/rnhd_out_if.sv
// Result channel of the ray sensor: one result per finished query.
// Depends on rnhd_pkg for the length width.
interface rnhd_out_if ();
  logic                       valid;
  logic                       ready;
  logic [rnhd_pkg::LEN_W-1:0] distance;
  logic [rnhd_pkg::LEN_W-1:0] visible_length;
  logic [1:0]                 ray_state;

  modport source (output valid, distance, visible_length, ray_state, input ready);
  modport sink   (input valid, distance, visible_length, ray_state, output ready);
endinterface

>>> rtl/core/rnhd_cfg_if.sv
// Configuration write channel of the ray sensor: register index and write data.
// Depends on rnhd_pkg for the index and length widths.
interface rnhd_cfg_if #(
  parameter int COORD_WIDTH = rnhd_pkg::COORD_WIDTH_DEF
) ();
  localparam int DATA_W = (COORD_WIDTH > rnhd_pkg::LEN_W) ? COORD_WIDTH : rnhd_pkg::LEN_W;

  logic                           valid;
  logic                           ready;
  logic [rnhd_pkg::CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]              data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/rnhd_front.sv
// Front pipeline: origin offset, saturated differences, squares and their sum.
// Depends on rnhd_pkg and rnhd_in_if; pushes finished items into rnhd_queue.
module rnhd_front #(
  parameter int COORD_WIDTH = rnhd_pkg::COORD_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  rnhd_in_if.sink                                    in_ch,
  input  logic [COORD_WIDTH-1:0]                     offset [3],
  input  logic [$clog2(rnhd_pkg::QUEUE_DEPTH+1)-1:0] q_count,
  output logic                                       push,
  output logic [2*COORD_WIDTH+rnhd_pkg::LEN_SQ_W+1:0] push_data
);
  localparam int CW    = COORD_WIDTH;
  localparam int SQ_W  = 2 * CW;
  localparam int LW    = rnhd_pkg::LEN_W;
  localparam int LSW   = rnhd_pkg::LEN_SQ_W;
  localparam int CNT_W = $clog2(rnhd_pkg::QUEUE_DEPTH + 1);

  function automatic logic [CW-1:0] sat_sum(input logic [CW:0] s);
    logic [CW-1:0] r;
    if (s[CW] != s[CW-1]) begin
      r = s[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      r = s[CW-1:0];
    end
    return r;
  endfunction

  logic [CW-1:0]  host [3];
  logic [CW-1:0]  point [3];

  logic           s1_v_r, s2_v_r, s3_v_r;
  logic [CW-1:0]  org_r [3];
  logic [CW-1:0]  org_nxt [3];
  logic [CW-1:0]  pt_r [3];
  logic [LW-1:0]  s1_mr_r, s2_mr_r;
  logic           s1_pv_r, s2_pv_r, s3_pv_r;
  logic           s1_last_r, s2_last_r, s3_last_r;
  logic [CW-1:0]  mag_r [3];
  logic [CW-1:0]  mag_nxt [3];
  logic [SQ_W-1:0] sq_r [3];
  logic [SQ_W-1:0] sq_nxt [3];
  logic [LSW-1:0] mr2_r;
  logic [CW-1:0]  diff [3];
  logic [CNT_W:0] used;
  logic           take;
  logic [SQ_W-1:0] d2;

  assign host[0]  = in_ch.host_x;
  assign host[1]  = in_ch.host_y;
  assign host[2]  = in_ch.host_z;
  assign point[0] = in_ch.point_x;
  assign point[1] = in_ch.point_y;
  assign point[2] = in_ch.point_z;

  assign used = (CNT_W+1)'(q_count) + (CNT_W+1)'(s1_v_r) + (CNT_W+1)'(s2_v_r)
              + (CNT_W+1)'(s3_v_r);
  assign in_ch.ready = (used < (CNT_W+1)'(rnhd_pkg::QUEUE_DEPTH));
  assign take = in_ch.valid && in_ch.ready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      org_nxt[i] = sat_sum({host[i][CW-1], host[i]} + {offset[i][CW-1], offset[i]});
      diff[i]    = sat_sum({pt_r[i][CW-1], pt_r[i]} - {org_r[i][CW-1], org_r[i]});
      mag_nxt[i] = diff[i][CW-1] ? (~diff[i] + 1'b1) : diff[i];
      sq_nxt[i]  = SQ_W'(mag_r[i]) * SQ_W'(mag_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= take;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    org_r     <= org_nxt;
    pt_r      <= point;
    s1_mr_r   <= in_ch.min_range;
    s1_pv_r   <= in_ch.point_valid;
    s1_last_r <= in_ch.last_point;
    mag_r     <= mag_nxt;
    s2_mr_r   <= s1_mr_r;
    s2_pv_r   <= s1_pv_r;
    s2_last_r <= s1_last_r;
    sq_r      <= sq_nxt;
    mr2_r     <= LSW'(s2_mr_r) * LSW'(s2_mr_r);
    s3_pv_r   <= s2_pv_r;
    s3_last_r <= s2_last_r;
  end

  assign d2        = sq_r[0] + sq_r[1] + sq_r[2];
  assign push      = s3_v_r;
  assign push_data = {d2, mr2_r, s3_pv_r, s3_last_r};

endmodule

>>> rtl/core/rnhd_queue.sv
// Short register queue that decouples the front pipeline from the back end.
// No dependencies beyond its parameters.
module rnhd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           head_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  mem_r [DEPTH];
  logic [ADDR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data = mem_r[rd_ptr_r];
  assign count     = count_r;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CNT_W'(DEPTH)))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue pop while empty");
`endif

endmodule

>>> rtl/core/rnhd_back.sv
// Back end: running minimum of squared distances, bit-serial square root, result register.
// Depends on rnhd_pkg and rnhd_out_if; takes items from rnhd_queue.
module rnhd_back #(
  parameter int COORD_WIDTH = rnhd_pkg::COORD_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  rnhd_pkg::cfg_t                              cfg,
  input  logic [2*COORD_WIDTH+rnhd_pkg::LEN_SQ_W+1:0] head_data,
  input  logic                                        q_empty,
  output logic                                        pop,
  rnhd_out_if.source                                  out_ch
);
  localparam int SQ_W   = 2 * COORD_WIDTH;
  localparam int LW     = rnhd_pkg::LEN_W;
  localparam int LSW    = rnhd_pkg::LEN_SQ_W;
  localparam int CMP_W  = (SQ_W > LSW) ? SQ_W : LSW;
  localparam int REM_W  = LW + 3;
  localparam int STEP_W = $clog2(LW);

  rnhd_pkg::back_state_t state_r, state_nxt;

  logic [SQ_W-1:0]   h_d2;
  logic [LSW-1:0]    h_mr2;
  logic              h_pv, h_last;

  logic              query_open_r, query_open_nxt;
  logic [LSW-1:0]    best_r, best_nxt;
  logic [LSW-1:0]    best_base, best_new;
  logic              upd, hit, out_free, sq_done, pop_last;

  logic [LSW-1:0]    rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt, rem_sh, trial, rem_step;
  logic [LW-1:0]     root_r, root_nxt, root_step;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              ge;

  logic              out_valid_r, out_valid_nxt;
  logic [LW-1:0]     dist_r, dist_nxt;
  logic [LW-1:0]     vis_r, vis_nxt;
  logic [1:0]        st_r, st_nxt;

  assign {h_d2, h_mr2, h_pv, h_last} = head_data;

  always_comb begin
    best_base = query_open_r ? best_r : cfg.len_sq;
    upd       = h_pv && (CMP_W'(h_d2) < CMP_W'(best_base))
                     && (CMP_W'(h_d2) >= CMP_W'(h_mr2));
    best_new  = upd ? LSW'(h_d2) : best_base;
    hit       = cfg.rule_present && (best_new < cfg.len_sq);
    out_free  = !out_valid_r || out_ch.ready;
    pop       = (state_r == rnhd_pkg::BK_RUN) && !q_empty && (!h_last || out_free);
    pop_last  = pop && h_last;
    sq_done   = (state_r == rnhd_pkg::BK_ROOT) && (step_r == '0);
    rem_sh    = {rem_r[REM_W-3:0], rad_r[LSW-1 -: 2]};
    trial     = REM_W'({root_r, 2'b01});
    ge        = (rem_sh >= trial);
    rem_step  = ge ? (rem_sh - trial) : rem_sh;
    root_step = {root_r[LW-2:0], ge};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rnhd_pkg::BK_RUN: begin
        if (pop_last && hit) begin
          state_nxt = rnhd_pkg::BK_ROOT;
        end
      end
      rnhd_pkg::BK_ROOT: begin
        if (sq_done) begin
          state_nxt = rnhd_pkg::BK_RUN;
        end
      end
      default: state_nxt = rnhd_pkg::BK_RUN;
    endcase
  end

  always_comb begin
    query_open_nxt = query_open_r;
    best_nxt       = best_r;
    rad_nxt        = rad_r;
    rem_nxt        = rem_r;
    root_nxt       = root_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    dist_nxt       = dist_r;
    vis_nxt        = vis_r;
    st_nxt         = st_r;
    unique case (state_r)
      rnhd_pkg::BK_RUN: begin
        if (pop) begin
          query_open_nxt = !h_last;
          best_nxt       = best_new;
        end
        if (pop_last && hit) begin
          rad_nxt  = best_new;
          rem_nxt  = '0;
          root_nxt = '0;
          step_nxt = STEP_W'(LW - 1);
        end else if (pop_last) begin
          out_valid_nxt = 1'b1;
          dist_nxt      = cfg.ray_length;
          vis_nxt       = cfg.ray_length;
          st_nxt        = cfg.ray_disabled ? rnhd_pkg::ST_DISABLED : rnhd_pkg::ST_NO_HIT;
        end
      end
      rnhd_pkg::BK_ROOT: begin
        rad_nxt  = {rad_r[LSW-3:0], 2'b00};
        rem_nxt  = rem_step;
        root_nxt = root_step;
        step_nxt = step_r - 1'b1;
        if (sq_done) begin
          out_valid_nxt = 1'b1;
          dist_nxt      = root_step;
          vis_nxt       = cfg.ray_disabled ? cfg.ray_length : root_step;
          st_nxt        = cfg.ray_disabled ? rnhd_pkg::ST_DISABLED : rnhd_pkg::ST_HIT;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rnhd_pkg::BK_RUN;
      query_open_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      query_open_r <= query_open_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    step_r <= step_nxt;
    dist_r <= dist_nxt;
    vis_r  <= vis_nxt;
    st_r   <= st_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.distance       = dist_r;
  assign out_ch.visible_length = vis_r;
  assign out_ch.ray_state      = st_r;

`ifndef SYNTHESIS
  a_root_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (!out_valid_r || out_ch.ready))
    else $error("root finished while result register busy");
  a_root_query_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rnhd_pkg::BK_ROOT) |-> !query_open_r)
    else $error("query open during root");
`endif

endmodule

>>> rtl/core/ray_nearest_hit_distance.sv
// Nearest-hit distance ray sensor, top level: configuration registers, front, queue, back.
// Path: front pipeline, queue, back end, result register; a query that ends on a hit first
// runs the bit-serial square root (25 iterations, one result bit per cycle) in the back end.
// Throughput: one point per cycle while the queue has room; the square root holds the back end.
// Reset (rst_n low, synchronous): registers to their defaults, queue, pipeline and query cleared.
// Depends on rnhd_pkg, the channel interfaces, rnhd_front, rnhd_queue and rnhd_back.
module ray_nearest_hit_distance #(
  parameter int COORD_WIDTH = rnhd_pkg::COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rnhd_in_if.sink     in_ch,
  rnhd_out_if.source  out_ch,
  rnhd_cfg_if.sink    cfg_ch
);
  localparam int CW    = COORD_WIDTH;
  localparam int LW    = rnhd_pkg::LEN_W;
  localparam int LSW   = rnhd_pkg::LEN_SQ_W;
  localparam int ENT_W = 2 * CW + LSW + 2;
  localparam int CNT_W = $clog2(rnhd_pkg::QUEUE_DEPTH + 1);

  logic [LW-1:0]  ray_length_r;
  logic [LSW-1:0] len_sq_r;
  logic [CW-1:0]  offset_r [3];
  logic           rule_present_r;
  logic           ray_disabled_r;

  rnhd_pkg::cfg_t   cfg;
  logic             push, pop;
  logic [ENT_W-1:0] push_data, head_data;
  logic [CNT_W-1:0] q_count;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_length_r   <= rnhd_pkg::LEN_RESET;
      len_sq_r       <= rnhd_pkg::LEN_SQ_RESET;
      offset_r[0]    <= '0;
      offset_r[1]    <= '0;
      offset_r[2]    <= '0;
      rule_present_r <= 1'b1;
      ray_disabled_r <= 1'b0;
    end else begin
      len_sq_r <= LSW'(ray_length_r) * LSW'(ray_length_r);
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          rnhd_pkg::REG_RAY_LENGTH:   ray_length_r   <= cfg_ch.data[LW-1:0];
          rnhd_pkg::REG_OFFSET_X:     offset_r[0]    <= cfg_ch.data[CW-1:0];
          rnhd_pkg::REG_OFFSET_Y:     offset_r[1]    <= cfg_ch.data[CW-1:0];
          rnhd_pkg::REG_OFFSET_Z:     offset_r[2]    <= cfg_ch.data[CW-1:0];
          rnhd_pkg::REG_RULE_PRESENT: rule_present_r <= cfg_ch.data[0];
          rnhd_pkg::REG_RAY_DISABLED: ray_disabled_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
    end
  end

  assign cfg.ray_length   = ray_length_r;
  assign cfg.len_sq       = len_sq_r;
  assign cfg.rule_present = rule_present_r;
  assign cfg.ray_disabled = ray_disabled_r;

  rnhd_front #(
    .COORD_WIDTH (CW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .offset    (offset_r),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  rnhd_queue #(
    .WIDTH (ENT_W),
    .DEPTH (rnhd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .count     (q_count)
  );

  rnhd_back #(
    .COORD_WIDTH (CW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .head_data (head_data),
    .q_empty   (q_count == '0),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for ray_nearest_hit_distance: streams collision-point queries,
// predicts each nearest-hit result and compares it with the result channel field by field.
// Depends on rnhd_pkg, the rnhd channel interfaces and the ray_nearest_hit_distance top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW     = rnhd_pkg::COORD_WIDTH_DEF;
  localparam int LW     = rnhd_pkg::LEN_W;
  localparam int IW     = rnhd_pkg::CFG_IDX_W;
  localparam int SETTLE = 40;

  typedef struct {
    logic signed [CW-1:0] px, py, pz, hx, hy, hz;
    logic [LW-1:0]        min_range;
    logic                 valid_pt;
    logic                 last;
  } point_item_t;

  typedef struct {
    logic [LW-1:0]        distance;
    logic [LW-1:0]        visible;
    rnhd_pkg::ray_state_t state;
  } ray_result_t;

  logic clk;
  logic rst_n;

  rnhd_in_if  in_ch ();
  rnhd_out_if out_ch ();
  rnhd_cfg_if cfg_ch ();

  ray_nearest_hit_distance DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  logic [LW-1:0]        ray_len;
  logic signed [CW-1:0] off_x, off_y, off_z;
  logic                 rule_on, ray_off;
  longint unsigned      best_sq;
  logic                 query_open;

  ray_result_t hit_expect_q[$];
  ray_result_t exp_r;

  int snd_idle_pct = 30;
  int rcv_idle_pct = 83;
  int mismatches;
  int points_sent;
  int results_seen;
  int reg_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("ray_nearest_hit_distance verification failed");
    $finish;
  end

  function automatic longint clamp_coord(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void reset_sensor_model();
    ray_len    = rnhd_pkg::LEN_RESET;
    off_x      = '0;
    off_y      = '0;
    off_z      = '0;
    rule_on    = 1'b1;
    ray_off    = 1'b0;
    best_sq    = 64'(ray_len) * 64'(ray_len);
    query_open = 1'b0;
  endfunction

  function automatic void apply_reg(logic [IW-1:0] idx, logic [LW-1:0] val);
    case (idx)
      rnhd_pkg::REG_RAY_LENGTH:   ray_len = val;
      rnhd_pkg::REG_OFFSET_X:     off_x = val[CW-1:0];
      rnhd_pkg::REG_OFFSET_Y:     off_y = val[CW-1:0];
      rnhd_pkg::REG_OFFSET_Z:     off_z = val[CW-1:0];
      rnhd_pkg::REG_RULE_PRESENT: rule_on = val[0];
      rnhd_pkg::REG_RAY_DISABLED: ray_off = val[0];
      default: ;
    endcase
  endfunction

  function automatic void nearest_hit_step(point_item_t it);
    longint unsigned len_sq, d2, mr2, near_len;
    longint          ox, oy, oz, dx, dy, dz;
    ray_result_t     r;
    len_sq = 64'(ray_len) * 64'(ray_len);
    if (!query_open) begin
      best_sq    = len_sq;
      query_open = 1'b1;
    end
    if (it.valid_pt) begin
      ox  = clamp_coord(longint'(it.hx) + longint'(off_x));
      oy  = clamp_coord(longint'(it.hy) + longint'(off_y));
      oz  = clamp_coord(longint'(it.hz) + longint'(off_z));
      dx  = clamp_coord(longint'(it.px) - ox);
      dy  = clamp_coord(longint'(it.py) - oy);
      dz  = clamp_coord(longint'(it.pz) - oz);
      d2  = dx * dx + dy * dy + dz * dz;
      mr2 = 64'(it.min_range) * 64'(it.min_range);
      if (d2 < best_sq && d2 >= mr2) best_sq = d2;
    end
    if (!it.last) return;
    query_open = 1'b0;
    if (rule_on && best_sq < len_sq) near_len = floor_root(best_sq);
    else near_len = 64'(ray_len);
    r.distance = near_len[LW-1:0];
    if (ray_off) begin
      r.state   = rnhd_pkg::ST_DISABLED;
      r.visible = ray_len;
    end else if (r.distance < ray_len) begin
      r.state   = rnhd_pkg::ST_HIT;
      r.visible = r.distance;
    end else begin
      r.state   = rnhd_pkg::ST_NO_HIT;
      r.visible = ray_len;
    end
    hit_expect_q.push_back(r);
  endfunction

  function automatic void flag_mismatch(string what, longint unsigned exp_v,
                                        longint unsigned act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected %0d, got %0d", what, exp_v, act_v);
  endfunction

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (hit_expect_q.size() == 0) begin
        flag_mismatch("result with no query pending, distance", 0, out_ch.distance);
      end else begin
        exp_r = hit_expect_q.pop_front();
        if (out_ch.distance !== exp_r.distance)
          flag_mismatch("distance", exp_r.distance, out_ch.distance);
        if (out_ch.visible_length !== exp_r.visible)
          flag_mismatch("visible_length", exp_r.visible, out_ch.visible_length);
        if (out_ch.ray_state !== exp_r.state)
          flag_mismatch("ray_state", exp_r.state, out_ch.ray_state);
      end
    end
  end

  function automatic point_item_t mk_point(longint px, longint py, longint pz, longint hx,
                                           longint hy, longint hz, longint mr,
                                           logic pv, logic last);
    point_item_t it;
    it.px        = CW'(px);
    it.py        = CW'(py);
    it.pz        = CW'(pz);
    it.hx        = CW'(hx);
    it.hy        = CW'(hy);
    it.hz        = CW'(hz);
    it.min_range = LW'(mr);
    it.valid_pt  = pv;
    it.last      = last;
    return it;
  endfunction

  task automatic send_point(input point_item_t it);
    while ($urandom_range(99) < snd_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.point_x     <= it.px;
    in_ch.point_y     <= it.py;
    in_ch.point_z     <= it.pz;
    in_ch.host_x      <= it.hx;
    in_ch.host_y      <= it.hy;
    in_ch.host_z      <= it.hz;
    in_ch.min_range   <= it.min_range;
    in_ch.point_valid <= it.valid_pt;
    in_ch.last_point  <= it.last;
    do @(posedge clk); while (!in_ch.ready);
    nearest_hit_step(it);
    points_sent++;
  endtask

  task automatic drain_block(input int settle);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (hit_expect_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [LW-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, val);
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [LW-1:0] pick_offset();
    logic [CW-1:0] v;
    case ($urandom_range(9))
      0:       v = {1'b0, {(CW-1){1'b1}}};
      1:       v = {1'b1, {(CW-1){1'b0}}};
      2:       v = CW'($urandom);
      default: v = CW'(longint'($urandom_range(16384)) - 8192);
    endcase
    return {1'($urandom_range(1)), v};
  endfunction

  task automatic randomize_config();
    logic [LW-1:0] len;
    case ($urandom_range(9))
      0:       len = '0;
      1:       len = '1;
      2:       len = LW'(1);
      default: len = LW'($urandom_range(1 << 16, 1 << 10));
    endcase
    write_reg(rnhd_pkg::REG_RAY_LENGTH, len);
    write_reg(rnhd_pkg::REG_OFFSET_X, pick_offset());
    write_reg(rnhd_pkg::REG_OFFSET_Y, pick_offset());
    write_reg(rnhd_pkg::REG_OFFSET_Z, pick_offset());
    write_reg(rnhd_pkg::REG_RULE_PRESENT,
              LW'($urandom_range(6) != 0) | (LW'($urandom) & ~LW'(1)));
    write_reg(rnhd_pkg::REG_RAY_DISABLED,
              LW'($urandom_range(4) == 0) | (LW'($urandom) & ~LW'(1)));
  endtask

  function automatic longint rand_delta(longint spread);
    return longint'($urandom_range(int'(2 * spread))) - spread;
  endfunction

  task automatic run_queries(input int n_items);
    point_item_t   it;
    longint        spread, hx, hy, hz;
    logic [LW-1:0] mr;
    int            npts, sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(24) == 0) drain_block(0);
      npts   = ($urandom_range(15) == 0) ? $urandom_range(20, 8) : $urandom_range(6, 1);
      spread = (ray_len == 0) ? 64 : ((ray_len > (1 << 22)) ? (1 << 22) : ray_len);
      hx     = longint'($urandom_range(1 << 20)) - (1 << 19);
      hy     = longint'($urandom_range(1 << 20)) - (1 << 19);
      hz     = longint'($urandom_range(1 << 20)) - (1 << 19);
      mr     = ($urandom_range(2) == 0) ? '0 : LW'($urandom_range(int'(spread * 3 / 4)));
      for (int k = 0; k < npts; k++) begin
        if ($urandom_range(9) == 0) begin
          it = mk_point(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                        CW'($urandom), CW'($urandom), LW'($urandom),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
          it = mk_point(clamp_coord(hx + off_x + rand_delta(spread)),
                        clamp_coord(hy + off_y + rand_delta(spread)),
                        clamp_coord(hz + off_z + rand_delta(spread)),
                        hx, hy, hz, mr, $urandom_range(11) != 0, k == npts - 1);
        end
        send_point(it);
        sent++;
      end
    end
  endtask

  task automatic test_query_bounds();
    send_point(mk_point(0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
    send_point(mk_point(2048, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    send_point(mk_point(4096, 0, 0, 0, 0, 0, 1000, 1'b1, 1'b0));
    send_point(mk_point(0, 1000, 0, 0, 0, 0, 1000, 1'b1, 1'b0));
    send_point(mk_point(0, 0, 999, 0, 0, 0, 1000, 1'b1, 1'b0));
    send_point(mk_point(0, -1000, 0, 0, 0, 0, 1000, 1'b1, 1'b0));
    send_point(mk_point(5, 5, 5, 0, 0, 0, 1000, 1'b0, 1'b1));
  endtask

  task automatic test_rule_and_disable();
    drain_block(SETTLE);
    write_reg(rnhd_pkg::REG_RULE_PRESENT, LW'(0));
    send_point(mk_point(100, 200, 300, 0, 0, 0, 0, 1'b1, 1'b0));
    send_point(mk_point(-700, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    drain_block(SETTLE);
    write_reg(rnhd_pkg::REG_RULE_PRESENT, LW'(1));
    write_reg(rnhd_pkg::REG_RAY_DISABLED, LW'(1));
    send_point(mk_point(1500, 1500, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    drain_block(SETTLE);
    write_reg(rnhd_pkg::REG_RAY_DISABLED, LW'(0));
  endtask

  task automatic test_length_change();
    drain_block(SETTLE);
    write_reg(rnhd_pkg::REG_RAY_LENGTH, LW'(8192));
    send_point(mk_point(6000, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
    drain_block(SETTLE);
    write_reg(rnhd_pkg::REG_RAY_LENGTH, LW'(4096));
    send_point(mk_point(0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
  endtask

  task automatic test_saturation();
    drain_block(SETTLE);
    write_reg(rnhd_pkg::REG_RAY_LENGTH, '1);
    write_reg(rnhd_pkg::REG_OFFSET_X, {2'b00, {(CW-1){1'b1}}});
    write_reg(rnhd_pkg::REG_OFFSET_Y, {2'b01, {(CW-1){1'b0}}});
    write_reg(rnhd_pkg::REG_OFFSET_Z, {2'b10, {(CW-1){1'b1}}});
    send_point(mk_point(-(1 << (CW-1)), (1 << (CW-1)) - 1, -(1 << (CW-1)),
                        (1 << (CW-1)) - 1, -(1 << (CW-1)), (1 << (CW-1)) - 1,
                        0, 1'b1, 1'b0));
    send_point(mk_point((1 << (CW-1)) - 1, 0, -1, -(1 << (CW-1)), 0, 0,
                        (1 << LW) - 1, 1'b1, 1'b0));
    send_point(mk_point(12345, -23456, 34567, 0, 0, 0, 0, 1'b1, 1'b1));
    drain_block(SETTLE);
    write_reg(rnhd_pkg::REG_RAY_LENGTH, LW'(0));
    send_point(mk_point(0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
  endtask

  task automatic test_random_queries();
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 30 : ((ph == 1) ? 83 : 0);
      rcv_idle_pct = (ph == 0) ? 83 : ((ph == 1) ? 30 : 0);
      for (int blk = 0; blk < 3; blk++) begin
        drain_block(SETTLE);
        randomize_config();
        run_queries(90);
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.point_x     = '0;
    in_ch.point_y     = '0;
    in_ch.point_z     = '0;
    in_ch.host_x      = '0;
    in_ch.host_y      = '0;
    in_ch.host_z      = '0;
    in_ch.min_range   = '0;
    in_ch.point_valid = 1'b0;
    in_ch.last_point  = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    out_ch.ready      = 1'b0;
    reset_sensor_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_query_bounds();
    test_rule_and_disable();
    test_length_change();
    test_saturation();
    test_random_queries();

    drain_block(SETTLE);
    $display("Sent %0d points, checked %0d query results across %0d register writes",
             points_sent, results_seen, reg_writes);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && hit_expect_q.size() == 0) begin
      $display("ray_nearest_hit_distance verification clean");
    end else begin
      $display("ray_nearest_hit_distance verification failed");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/core/rnhd_pkg.sv
rtl/core/rnhd_in_if.sv
rtl/core/rnhd_out_if.sv
rtl/core/rnhd_cfg_if.sv
rtl/core/rnhd_front.sv
rtl/core/rnhd_queue.sv
rtl/core/rnhd_back.sv
rtl/core/ray_nearest_hit_distance.sv
dv/testbench.sv
